### design/lpca_pkg.sv
// Shared constants and helper functions for the line pair closest approach block.
// No dependencies.
package lpca_pkg;

    localparam int unsigned CUT_RESET = 32'd4295;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic signed [1:0] SIDE_POS = 2'sb01;
    localparam logic signed [1:0] SIDE_NEG = 2'sb11;
    localparam logic signed [1:0] SIDE_ZERO = 2'sb00;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
            begin
                r = SAT_MAX;
            end
            else if (v < -64'sd2147483648)
            begin
                r = SAT_MIN;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // Round half up from Q.28 scaling: floor((x + 2^27) / 2^28).
    function automatic logic signed [63:0] rnd28(input logic signed [95:0] x);
        logic signed [95:0] y;
        begin
            y = x + 96'sd134217728;
            return y[91:28];
        end
    endfunction

endpackage

### design/lpca_sqrt_stage.sv
// One restoring square root step, registered, with side data carried along.
// Depends on lpca_pkg.
module lpca_sqrt_stage
    import lpca_pkg::*;
#(
    parameter int RW = 36,
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [1:0]    pair,
    input  logic [RW-1:0] root_in,
    input  logic [RW+1:0] rem_in,
    input  logic [DW-1:0] side_in,
    output logic          out_valid,
    output logic [RW-1:0] root_out,
    output logic [RW+1:0] rem_out,
    output logic [DW-1:0] side_out
);

    logic [RW+1:0] rem_shift;
    logic [RW+1:0] trial;
    logic          valid_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] rem_reg;
    logic [DW-1:0] side_reg;

    // Trial subtraction of one result bit.
    assign rem_shift = {rem_in[RW-1:0], pair};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            if (rem_shift >= trial)
            begin
                rem_reg <= rem_shift - trial;
                root_reg <= {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                root_reg <= {root_in[RW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg;
    assign root_out = root_reg;
    assign rem_out = rem_reg;
    assign side_out = side_reg;

endmodule

### design/lpca_isqrt.sv
// Pipelined floor square root of a 68-bit value, one result bit per stage.
// Depends on lpca_pkg and lpca_sqrt_stage.
module lpca_isqrt
    import lpca_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [67:0]   radicand,
    input  logic [DW-1:0] side_in,
    output logic          out_valid,
    output logic [33:0]   root,
    output logic [DW-1:0] side_out
);

    localparam int NS = 34;

    logic          v_w [NS+1];
    logic [33:0]   r_w [NS+1];
    logic [35:0]   m_w [NS+1];
    logic [DW+67:0] s_w [NS+1];

    assign v_w[0] = in_valid;
    assign r_w[0] = '0;
    assign m_w[0] = '0;
    assign s_w[0] = {radicand, side_in};

    // The radicand travels with the item; each stage consumes its top pair.
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        lpca_sqrt_stage #(.RW(34), .DW(DW + 68)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v_w[i]),
            .pair(s_w[i][DW + 67 - 2*i -: 2]),
            .root_in(r_w[i]), .rem_in(m_w[i]), .side_in(s_w[i]),
            .out_valid(v_w[i+1]), .root_out(r_w[i+1]), .rem_out(m_w[i+1]),
            .side_out(s_w[i+1])
        );
    end

    assign out_valid = v_w[NS];
    assign root = r_w[NS];
    assign side_out = s_w[NS][DW-1:0];

endmodule

### design/lpca_div.sv
// Pipelined unsigned divider: 31-bit quotient bits of num*2^28/den, saturating.
// Depends on lpca_pkg.
module lpca_div
    import lpca_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   num,
    input  logic [56:0]   den,
    input  logic [DW-1:0] side_in,
    output logic          out_valid,
    output logic [31:0]   quot,
    output logic [DW-1:0] side_out
);

    // Quotient above 2^31 saturates. Precheck: overflow when num*2^28 >= den*2^31,
    // i.e. num >= den*8. Otherwise 31 quotient bits, one per stage.
    localparam int NS = 31;

    logic          v_reg [NS+1];
    logic [91:0]   rem_reg [NS+1];
    logic [30:0]   q_reg [NS+1];
    logic [56:0]   d_reg [NS+1];
    logic          o_reg [NS+1];
    logic [DW-1:0] s_reg [NS+1];

    logic [91:0]   num_ext;
    logic [60:0]   den8;
    assign num_ext = {num, 28'd0};
    assign den8 = {den, 3'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Each stage decides one quotient bit from the most significant end.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            q_reg[0] <= '0;
            d_reg[0] <= den;
            o_reg[0] <= ({4'd0, num} >= {7'd0, den8});
            s_reg[0] <= side_in;
            for (int i = 1; i <= NS; i++)
            begin
                if (rem_reg[i-1] >= ({35'd0, d_reg[i-1]} << (NS - i)))
                begin
                    rem_reg[i] <= rem_reg[i-1] - ({35'd0, d_reg[i-1]} << (NS - i));
                    q_reg[i] <= q_reg[i-1] | (31'd1 << (NS - i));
                end
                else
                begin
                    rem_reg[i] <= rem_reg[i-1];
                    q_reg[i] <= q_reg[i-1];
                end
                d_reg[i] <= d_reg[i-1];
                o_reg[i] <= o_reg[i-1];
                s_reg[i] <= s_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign quot = o_reg[NS] ? 32'h8000_0000 : {1'b0, q_reg[NS]};
    assign side_out = s_reg[NS];

endmodule

### design/line_pair_closest_approach.sv
// Top level of the line pair closest approach pipeline.
// Depends on lpca_pkg, lpca_isqrt, lpca_udiv and lpca_div.
//
// Channel | Signals                         | Beat
// in      | in_valid, in_stall, 12 fields   | two lines, point and direction
// out     | out_valid, out_stall, 12 fields | closest points, params, gaps
// cfg     | cfg_we, cfg_data                | parallel_cut
//
// One beat enters per cycle while the output is not stalled. In order, each beat passes the norm
// square roots, the unit divider, the parameter dividers and the gap square roots, with nine
// single register stages among them.
// Reset clears all valid bits and loads parallel_cut with its default.
// An output stall on a valid result beat freezes the whole pipeline; no beat is lost or repeated.
module line_pair_closest_approach
    import lpca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] line1_point_x,
    input  logic signed [31:0] line1_point_y,
    input  logic signed [31:0] line1_point_z,
    input  logic signed [31:0] line1_dir_x,
    input  logic signed [31:0] line1_dir_y,
    input  logic signed [31:0] line1_dir_z,
    input  logic signed [31:0] line2_point_x,
    input  logic signed [31:0] line2_point_y,
    input  logic signed [31:0] line2_point_z,
    input  logic signed [31:0] line2_dir_x,
    input  logic signed [31:0] line2_dir_y,
    input  logic signed [31:0] line2_dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] param_one,
    output logic signed [31:0] param_two,
    output logic signed [31:0] near1_x,
    output logic signed [31:0] near1_y,
    output logic signed [31:0] near1_z,
    output logic signed [31:0] near2_x,
    output logic signed [31:0] near2_y,
    output logic signed [31:0] near2_z,
    output logic [32:0]        gap_3d,
    output logic [32:0]        gap_xy,
    output logic               near_parallel,
    output logic signed [1:0]  side_sign
);

    // Whole pipeline advances unless the output holds a beat that is stalled.
    logic en;
    logic out_valid_reg;
    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    logic [31:0] cut_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg <= CUT_RESET;
        end
        else if (cfg_we)
        begin
            cut_reg <= cfg_data;
        end
    end

    // Stage A: magnitudes and squared norms.
    typedef struct packed {
        logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z;
        logic signed [31:0] d1x, d1y, d1z, d2x, d2y, d2z;
    } geo_t;

    geo_t geo_in;
    assign geo_in = '{line1_point_x, line1_point_y, line1_point_z,
                      line2_point_x, line2_point_y, line2_point_z,
                      line1_dir_x, line1_dir_y, line1_dir_z,
                      line2_dir_x, line2_dir_y, line2_dir_z};

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        logic [32:0] e;
        begin
            e = v[31] ? -{v[31], v} : {1'b0, v};
            return e[31:0] | {e[32], 31'd0};
        end
    endfunction

    logic        a_v_reg;
    geo_t        a_g_reg;
    logic [63:0] a_sq_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_g_reg <= geo_in;
            a_sq_reg[0] <= mag(line1_dir_x) * mag(line1_dir_x);
            a_sq_reg[1] <= mag(line1_dir_y) * mag(line1_dir_y);
            a_sq_reg[2] <= mag(line1_dir_z) * mag(line1_dir_z);
            a_sq_reg[3] <= mag(line2_dir_x) * mag(line2_dir_x);
            a_sq_reg[4] <= mag(line2_dir_y) * mag(line2_dir_y);
            a_sq_reg[5] <= mag(line2_dir_z) * mag(line2_dir_z);
        end
    end

    logic [67:0] n1sq, n2sq;
    assign n1sq = {4'd0, a_sq_reg[0]} + {4'd0, a_sq_reg[1]} + {4'd0, a_sq_reg[2]};
    assign n2sq = {4'd0, a_sq_reg[3]} + {4'd0, a_sq_reg[4]} + {4'd0, a_sq_reg[5]};

    // Norms of both directions; the second root rides as side data on a second unit.
    localparam int GW = $bits(geo_t);
    logic        r1_v, r2_v;
    logic [33:0] r1_root, r2_root;
    geo_t        r1_g, r2_g;
    logic [GW+33:0] r2_side;

    lpca_isqrt #(.DW(GW)) u_norm1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v_reg), .radicand(n1sq),
        .side_in(a_g_reg), .out_valid(r1_v), .root(r1_root), .side_out(r1_g)
    );
    lpca_isqrt #(.DW(GW)) u_norm2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v_reg), .radicand(n2sq),
        .side_in(a_g_reg), .out_valid(r2_v), .root(r2_root), .side_out(r2_g)
    );
    assign r2_side = {r2_root, r2_g};

    // Unit components: |d|*2^28/norm rounded half up and capped, in a dedicated
    // pipelined divider that handles all six components at once.
    logic signed [31:0] d_comp [6];

    assign d_comp[0] = r1_g.d1x;
    assign d_comp[1] = r1_g.d1y;
    assign d_comp[2] = r1_g.d1z;
    assign d_comp[3] = r1_g.d2x;
    assign d_comp[4] = r1_g.d2y;
    assign d_comp[5] = r1_g.d2z;

    typedef struct packed {
        geo_t        g;
        logic [33:0] nrm1;
        logic [33:0] nrm2;
    } uside_t;

    localparam int UW = $bits(uside_t);
    uside_t us_in;
    assign us_in = '{r1_g, r1_root, r2_side[GW +: 34]};

    logic [31:0] unit_mag [6];
    logic        unit_v;
    uside_t      unit_side;

    lpca_udiv #(.DW(UW)) u_unit (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r1_v && r2_v),
        .m0(mag(d_comp[0])), .m1(mag(d_comp[1])), .m2(mag(d_comp[2])),
        .m3(mag(d_comp[3])), .m4(mag(d_comp[4])), .m5(mag(d_comp[5])),
        .nrm1(r1_root), .nrm2(r2_side[GW +: 34]), .side_in(us_in),
        .out_valid(unit_v), .q0(unit_mag[0]), .q1(unit_mag[1]), .q2(unit_mag[2]),
        .q3(unit_mag[3]), .q4(unit_mag[4]), .q5(unit_mag[5]), .side_out(unit_side)
    );

    // Stage C: signed unit vectors, dot products.
    logic signed [30:0] u1 [3], u2 [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u1[i] = 31'(unit_mag[i]);
            u2[i] = 31'(unit_mag[3+i]);
        end
        if (unit_side.g.d1x[31]) u1[0] = -u1[0];
        if (unit_side.g.d1y[31]) u1[1] = -u1[1];
        if (unit_side.g.d1z[31]) u1[2] = -u1[2];
        if (unit_side.g.d2x[31]) u2[0] = -u2[0];
        if (unit_side.g.d2y[31]) u2[1] = -u2[1];
        if (unit_side.g.d2z[31]) u2[2] = -u2[2];
    end

    logic               c_v_reg;
    geo_t               c_g_reg;
    logic signed [30:0] c_u1_reg [3], c_u2_reg [3];
    logic               c_z_reg;
    logic signed [61:0] c_pd_reg [3];
    logic signed [32:0] c_dl_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= unit_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_g_reg <= unit_side.g;
            c_z_reg <= (unit_side.nrm1 == '0) || (unit_side.nrm2 == '0);
            for (int i = 0; i < 3; i++)
            begin
                c_u1_reg[i] <= u1[i];
                c_u2_reg[i] <= u2[i];
                c_pd_reg[i] <= u1[i] * u2[i];
            end
            c_dl_reg[0] <= 33'(unit_side.g.p1x) - 33'(unit_side.g.p2x);
            c_dl_reg[1] <= 33'(unit_side.g.p1y) - 33'(unit_side.g.p2y);
            c_dl_reg[2] <= 33'(unit_side.g.p1z) - 33'(unit_side.g.p2z);
        end
    end

    // Stage D: cosine, clamp; dl*u products.
    logic signed [63:0] dot, cr;
    logic signed [29:0] cclamp;
    assign dot = 64'(c_pd_reg[0]) + 64'(c_pd_reg[1]) + 64'(c_pd_reg[2]);
    assign cr = rnd28(96'(dot));
    assign cclamp = (cr > 64'sd268435456) ? 30'sd268435456 :
                    (cr < -64'sd268435456) ? -30'sd268435456 : 30'(cr);

    logic               d_v_reg, d_z_reg;
    geo_t               d_g_reg;
    logic signed [30:0] d_u1_reg [3], d_u2_reg [3];
    logic signed [29:0] d_c_reg;
    logic signed [63:0] d_t1p_reg [3], d_t2p_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_g_reg <= c_g_reg;
            d_z_reg <= c_z_reg;
            d_c_reg <= cclamp;
            for (int i = 0; i < 3; i++)
            begin
                d_u1_reg[i] <= c_u1_reg[i];
                d_u2_reg[i] <= c_u2_reg[i];
                d_t1p_reg[i] <= c_dl_reg[i] * c_u1_reg[i];
                d_t2p_reg[i] <= c_dl_reg[i] * c_u2_reg[i];
            end
        end
    end

    // Stage E: sinsq, parallel decision, rounded projections.
    logic signed [59:0] csq;
    logic [57:0]        sinsq;
    logic signed [65:0] t1s, t2s;
    logic signed [63:0] t1r, t2r;
    assign csq = d_c_reg * d_c_reg;
    assign sinsq = 58'(58'h100_0000_0000_0000 - 58'(csq));
    assign t1s = 66'(d_t1p_reg[0]) + 66'(d_t1p_reg[1]) + 66'(d_t1p_reg[2]);
    assign t2s = 66'(d_t2p_reg[0]) + 66'(d_t2p_reg[1]) + 66'(d_t2p_reg[2]);
    assign t1r = rnd28(96'(t1s));
    assign t2r = rnd28(96'(t2s));

    logic               e_v_reg, e_par_reg;
    geo_t               e_g_reg;
    logic signed [30:0] e_u1_reg [3], e_u2_reg [3];
    logic signed [29:0] e_c_reg;
    logic [56:0]        e_s_reg;
    logic signed [34:0] e_t1_reg, e_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_g_reg <= d_g_reg;
            e_c_reg <= d_c_reg;
            e_s_reg <= sinsq[56:0];
            e_par_reg <= d_z_reg || (sinsq == '0) || (sinsq < {2'd0, cut_reg, 24'd0});
            e_t1_reg <= 35'(t1r);
            e_t2_reg <= 35'(t2r);
            for (int i = 0; i < 3; i++)
            begin
                e_u1_reg[i] <= d_u1_reg[i];
                e_u2_reg[i] <= d_u2_reg[i];
            end
        end
    end

    // Stage F: numerator products.
    logic               f_v_reg, f_par_reg;
    geo_t               f_g_reg;
    logic signed [30:0] f_u1_reg [3], f_u2_reg [3];
    logic [56:0]        f_s_reg;
    logic signed [64:0] f_t2c_reg, f_t1c_reg;
    logic signed [34:0] f_t1_reg, f_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_g_reg <= e_g_reg;
            f_par_reg <= e_par_reg;
            f_s_reg <= e_s_reg;
            f_t1_reg <= e_t1_reg;
            f_t2_reg <= e_t2_reg;
            f_t2c_reg <= e_t2_reg * e_c_reg;
            f_t1c_reg <= e_t1_reg * e_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                f_u1_reg[i] <= e_u1_reg[i];
                f_u2_reg[i] <= e_u2_reg[i];
            end
        end
    end

    // Numerators; parallel items get a unit divisor and are overridden later.
    logic signed [65:0] num1, num2;
    logic [63:0]        an1, an2;
    logic [56:0]        den;
    assign num1 = 66'(f_t2c_reg) - (66'(f_t1_reg) <<< 28);
    assign num2 = (66'(f_t2_reg) <<< 28) - 66'(f_t1c_reg);
    assign an1 = 64'(num1[65] ? -num1 : num1);
    assign an2 = 64'(num2[65] ? -num2 : num2);
    assign den = f_par_reg ? 57'd1 : f_s_reg;

    typedef struct packed {
        geo_t               g;
        logic               par;
        logic               neg1;
        logic               neg2;
        logic [6*31-1:0]    uv;
    } dside_t;

    localparam int SW = $bits(dside_t);
    dside_t ds_in, ds1_out, ds2_out;
    assign ds_in = '{f_g_reg, f_par_reg, num1[65], num2[65],
                     {f_u1_reg[0], f_u1_reg[1], f_u1_reg[2],
                      f_u2_reg[0], f_u2_reg[1], f_u2_reg[2]}};

    logic        q1_v, q2_v;
    logic [31:0] q1, q2;

    lpca_div #(.DW(SW)) u_div1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_v_reg), .num(an1), .den(den),
        .side_in(ds_in), .out_valid(q1_v), .quot(q1), .side_out(ds1_out)
    );
    lpca_div #(.DW(SW)) u_div2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_v_reg), .num(an2), .den(den),
        .side_in(ds_in), .out_valid(q2_v), .quot(q2), .side_out(ds2_out)
    );

    // Stage G: signed, saturated parameters; point offsets.
    logic signed [31:0] s1, s2;
    logic signed [30:0] gu [6];
    assign s1 = ds1_out.par ? 32'sd0 :
                sat32(ds1_out.neg1 ? -64'(q1) : 64'(q1));
    assign s2 = ds1_out.par ? 32'sd0 :
                sat32(ds1_out.neg2 ? -64'(q2) : 64'(q2));
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            gu[i] = ds1_out.uv[(5-i)*31 +: 31];
        end
    end

    logic               g_v_reg, g_par_reg;
    geo_t               g_g_reg;
    logic signed [31:0] g_s1_reg, g_s2_reg;
    logic signed [62:0] g_off_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_v_reg <= 1'b0;
        end
        else if (en)
        begin
            g_v_reg <= q1_v && q2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_g_reg <= ds1_out.g;
            g_par_reg <= ds1_out.par;
            g_s1_reg <= s1;
            g_s2_reg <= s2;
            for (int i = 0; i < 3; i++)
            begin
                g_off_reg[i] <= gu[i] * s1;
                g_off_reg[3+i] <= gu[3+i] * s2;
            end
        end
    end

    // Stage H: closest points and their differences.
    logic signed [31:0] pts [6];
    assign pts[0] = sat32(64'(g_g_reg.p1x) + rnd28(96'(g_off_reg[0])));
    assign pts[1] = sat32(64'(g_g_reg.p1y) + rnd28(96'(g_off_reg[1])));
    assign pts[2] = sat32(64'(g_g_reg.p1z) + rnd28(96'(g_off_reg[2])));
    assign pts[3] = sat32(64'(g_g_reg.p2x) + rnd28(96'(g_off_reg[3])));
    assign pts[4] = sat32(64'(g_g_reg.p2y) + rnd28(96'(g_off_reg[4])));
    assign pts[5] = sat32(64'(g_g_reg.p2z) + rnd28(96'(g_off_reg[5])));

    logic               h_v_reg, h_par_reg;
    logic signed [31:0] h_s1_reg, h_s2_reg;
    logic signed [31:0] h_pt_reg [6];
    logic [32:0]        h_ad_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_v_reg <= 1'b0;
        end
        else if (en)
        begin
            h_v_reg <= g_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [32:0] df;
        if (en)
        begin
            h_par_reg <= g_par_reg;
            h_s1_reg <= g_s1_reg;
            h_s2_reg <= g_s2_reg;
            for (int i = 0; i < 6; i++)
            begin
                h_pt_reg[i] <= pts[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                df = 33'(pts[i]) - 33'(pts[3+i]);
                h_ad_reg[i] <= df[32] ? 33'(-df) : 33'(df);
            end
        end
    end

    // Stage I: squared differences.
    logic               i_v_reg;
    logic [65:0]        i_sq_reg [3];

    typedef struct packed {
        logic               par;
        logic signed [31:0] s1, s2;
        logic signed [31:0] n1x, n1y, n1z, n2x, n2y, n2z;
    } oside_t;

    localparam int OW = $bits(oside_t);
    oside_t i_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_v_reg <= 1'b0;
        end
        else if (en)
        begin
            i_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_o_reg <= '{h_par_reg, h_s1_reg, h_s2_reg, h_pt_reg[0], h_pt_reg[1],
                         h_pt_reg[2], h_pt_reg[3], h_pt_reg[4], h_pt_reg[5]};
            for (int i = 0; i < 3; i++)
            begin
                i_sq_reg[i] <= h_ad_reg[i] * h_ad_reg[i];
            end
        end
    end

    logic [67:0] rad3, rad2;
    assign rad2 = {2'd0, i_sq_reg[0]} + {2'd0, i_sq_reg[1]};
    assign rad3 = rad2 + {2'd0, i_sq_reg[2]};

    logic        g3_v, g2_v;
    logic [33:0] g3_root, g2_root;
    oside_t      o3, o2;

    lpca_isqrt #(.DW(OW)) u_gap3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(i_v_reg), .radicand(rad3),
        .side_in(i_o_reg), .out_valid(g3_v), .root(g3_root), .side_out(o3)
    );
    lpca_isqrt #(.DW(OW)) u_gap2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(i_v_reg), .radicand(rad2),
        .side_in(i_o_reg), .out_valid(g2_v), .root(g2_root), .side_out(o2)
    );

    // Output register.
    oside_t      out_o_reg;
    logic [32:0] g3_reg, g2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= g3_v && g2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_o_reg <= o3;
            g3_reg <= g3_root[33] ? '1 : g3_root[32:0];
            g2_reg <= g2_root[33] ? '1 : g2_root[32:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign param_one = out_o_reg.s1;
    assign param_two = out_o_reg.s2;
    assign near1_x = out_o_reg.n1x;
    assign near1_y = out_o_reg.n1y;
    assign near1_z = out_o_reg.n1z;
    assign near2_x = out_o_reg.n2x;
    assign near2_y = out_o_reg.n2y;
    assign near2_z = out_o_reg.n2z;
    assign gap_3d = g3_reg;
    assign gap_xy = g2_reg;
    assign near_parallel = out_o_reg.par;
    assign side_sign = out_o_reg.par ? SIDE_ZERO :
                       (out_o_reg.s2 > 32'sd0) ? SIDE_POS : SIDE_NEG;

endmodule

### design/lpca_udiv.sv
// Pipelined rounded unit divider: six magnitudes over two norms, to Q2.28, capped.
// Depends on lpca_pkg.
module lpca_udiv
    import lpca_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   m0, m1, m2, m3, m4, m5,
    input  logic [33:0]   nrm1,
    input  logic [33:0]   nrm2,
    input  logic [DW-1:0] side_in,
    output logic          out_valid,
    output logic [31:0]   q0, q1, q2, q3, q4, q5,
    output logic [DW-1:0] side_out
);

    // q = floor((m*2^28 + floor(n/2)) / n), capped at 2^28. Since m <= n, the
    // quotient fits in 29 bits: one bit per stage over 29 stages.
    localparam int NS = 29;
    localparam logic [28:0] ONE = 29'h1000_0000;

    logic          v_reg [NS+1];
    logic [62:0]   r_reg [NS+1][6];
    logic [28:0]   q_reg [NS+1][6];
    logic [33:0]   n_reg [NS+1][2];
    logic [DW-1:0] s_reg [NS+1];
    logic [31:0]   m_w [6];

    assign m_w[0] = m0;
    assign m_w[1] = m1;
    assign m_w[2] = m2;
    assign m_w[3] = m3;
    assign m_w[4] = m4;
    assign m_w[5] = m5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Zero norm gives a zero quotient; the caller flags that case.
    always_ff @(posedge clk)
    begin
        logic [62:0] dsh;
        if (en)
        begin
            n_reg[0][0] <= nrm1;
            n_reg[0][1] <= nrm2;
            s_reg[0] <= side_in;
            for (int k = 0; k < 6; k++)
            begin
                r_reg[0][k] <= ({31'd0, m_w[k]} << 28) +
                               63'((k < 3 ? nrm1 : nrm2) >> 1);
                q_reg[0][k] <= '0;
            end
            for (int i = 1; i <= NS; i++)
            begin
                n_reg[i] <= n_reg[i-1];
                s_reg[i] <= s_reg[i-1];
                for (int k = 0; k < 6; k++)
                begin
                    dsh = {29'd0, n_reg[i-1][k < 3 ? 0 : 1]} << (NS - i);
                    if (n_reg[i-1][k < 3 ? 0 : 1] != '0 && r_reg[i-1][k] >= dsh)
                    begin
                        r_reg[i][k] <= r_reg[i-1][k] - dsh;
                        q_reg[i][k] <= q_reg[i-1][k] | (29'd1 << (NS - i));
                    end
                    else
                    begin
                        r_reg[i][k] <= r_reg[i-1][k];
                        q_reg[i][k] <= q_reg[i-1][k];
                    end
                end
            end
        end
    end

    function automatic logic [31:0] cap(input logic [28:0] q);
        return (q > ONE) ? {3'd0, ONE} : {3'd0, q};
    endfunction

    assign out_valid = v_reg[NS];
    assign q0 = cap(q_reg[NS][0]);
    assign q1 = cap(q_reg[NS][1]);
    assign q2 = cap(q_reg[NS][2]);
    assign q3 = cap(q_reg[NS][3]);
    assign q4 = cap(q_reg[NS][4]);
    assign q5 = cap(q_reg[NS][5]);
    assign side_out = s_reg[NS];

endmodule

### design/lpca_checker.sv
// Port-level checker for the line pair closest approach block, with its bind.
// Depends on lpca_pkg.
module lpca_checker
    import lpca_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               in_stall,
    input logic               near_parallel,
    input logic signed [1:0]  side_sign,
    input logic signed [31:0] param_one,
    input logic signed [31:0] param_two
);

    // A stalled result beat stays valid and keeps its second parameter.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(param_two))
        else $error("result beat changed under stall");

    // Parallel results carry zero parameters and a zero sign.
    a_par: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && near_parallel |->
            param_one == 32'sd0 && param_two == 32'sd0 && side_sign == SIDE_ZERO)
        else $error("parallel result has nonzero parameters");

    // Sign follows the second parameter.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !near_parallel |->
            (param_two > 32'sd0 && side_sign == SIDE_POS) ||
            (param_two <= 32'sd0 && side_sign == SIDE_NEG))
        else $error("side sign disagrees with second parameter");

    // Input is held off only while a result is stalled.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind line_pair_closest_approach lpca_checker u_lpca_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .in_stall(in_stall), .near_parallel(near_parallel), .side_sign(side_sign),
    .param_one(param_one), .param_two(param_two)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_pair_closest_approach: random and directed line pairs,
// checked field by field against a predictor of its own. Depends on lpca_pkg and the RTL.
module tb_top;
    import lpca_pkg::*;

    localparam int HOLD_CYCLES  = 450;
    localparam int IDLE_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 260;
    localparam int PHASE_ITEMS  = 350;
    localparam logic signed [127:0] ONE28 = 128'sd1 <<< 28;
    localparam logic signed [127:0] ONE56 = 128'sd1 <<< 56;

    // Index 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        logic [0:2][31:0] p1;
        logic [0:2][31:0] d1;
        logic [0:2][31:0] p2;
        logic [0:2][31:0] d2;
    } line_pair_t;

    typedef struct packed {
        logic [31:0]      s1;
        logic [31:0]      s2;
        logic [0:2][31:0] n1;
        logic [0:2][31:0] n2;
        logic [32:0]      g3;
        logic [32:0]      gxy;
        logic             par;
        logic [1:0]       side;
    } approach_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    line_pair_t drv;
    approach_t seen;

    line_pair_t pending_pairs[$];
    approach_t  expected_approach[$];
    logic [31:0] cut_copy;
    int errors;
    int beats_in;
    int beats_out;
    int parallel_seen;
    int idle_cycles;
    bit in_took;
    bit gaps_on;
    bit hold_req;
    int hold_left;
    int burst_left;
    int gap_left;
    int stall_pct;
    int pattern_cnt;

    line_pair_closest_approach DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line1_point_x (drv.p1[0]),
        .line1_point_y (drv.p1[1]),
        .line1_point_z (drv.p1[2]),
        .line1_dir_x   (drv.d1[0]),
        .line1_dir_y   (drv.d1[1]),
        .line1_dir_z   (drv.d1[2]),
        .line2_point_x (drv.p2[0]),
        .line2_point_y (drv.p2[1]),
        .line2_point_z (drv.p2[2]),
        .line2_dir_x   (drv.d2[0]),
        .line2_dir_y   (drv.d2[1]),
        .line2_dir_z   (drv.d2[2]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .param_one     (seen.s1),
        .param_two     (seen.s2),
        .near1_x       (seen.n1[0]),
        .near1_y       (seen.n1[1]),
        .near1_z       (seen.n1[2]),
        .near2_x       (seen.n2[0]),
        .near2_y       (seen.n2[1]),
        .near2_z       (seen.n2[2]),
        .gap_3d        (seen.g3),
        .gap_xy        (seen.gxy),
        .near_parallel (seen.par),
        .side_sign     (seen.side)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Floor square root of a wide unsigned value.
    function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
        logic [129:0] r;
        logic [129:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (130'd1 << i);
            if (t * t <= {2'b00, x})
            begin
                r = t;
            end
        end
        return r[127:0];
    endfunction

    // Round half up from Q.28 to integer units.
    function automatic logic signed [127:0] round_q28(input logic signed [127:0] x);
        return (x + 128'sd134217728) >>> 28;
    endfunction

    function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
        begin
            return 128'sd2147483647;
        end
        if (v < -128'sd2147483648)
        begin
            return -128'sd2147483648;
        end
        return v;
    endfunction

    // One component of a unit vector in Q2.28.
    function automatic logic signed [127:0] unit_comp(input logic signed [127:0] d,
                                                      input logic signed [127:0] norm);
        logic signed [127:0] m;
        logic signed [127:0] q;
        m = (d < 0) ? -d : d;
        q = ((m <<< 28) + (norm >>> 1)) / norm;
        if (q > ONE28)
        begin
            q = ONE28;
        end
        return (d < 0) ? -q : q;
    endfunction

    // Line parameter: n * 2^28 / den, truncated and saturated.
    function automatic logic signed [127:0] line_param(input logic signed [127:0] n,
                                                       input logic signed [127:0] den);
        logic signed [127:0] m;
        logic signed [127:0] q;
        m = (n < 0) ? -n : n;
        q = (m <<< 28) / den;
        if (q >= (128'sd1 <<< 31))
        begin
            q = 128'sd1 <<< 31;
        end
        return clamp32((n < 0) ? -q : q);
    endfunction

    // Expected closest approach of one line pair under the given cut.
    function automatic approach_t predict_approach(input line_pair_t a,
                                                   input logic [31:0] cut);
        logic signed [127:0] p1[3];
        logic signed [127:0] d1[3];
        logic signed [127:0] p2[3];
        logic signed [127:0] d2[3];
        logic signed [127:0] u1[3];
        logic signed [127:0] u2[3];
        logic signed [127:0] c1[3];
        logic signed [127:0] c2[3];
        logic signed [127:0] dd[3];
        logic signed [127:0] nrm1;
        logic signed [127:0] nrm2;
        logic signed [127:0] cosv;
        logic signed [127:0] sinsq;
        logic signed [127:0] t1;
        logic signed [127:0] t2;
        logic signed [127:0] s1;
        logic signed [127:0] s2;
        logic [127:0] g3;
        logic [127:0] g2;
        logic par;
        approach_t r;
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = $signed(a.p1[i]);
            d1[i] = $signed(a.d1[i]);
            p2[i] = $signed(a.p2[i]);
            d2[i] = $signed(a.d2[i]);
        end
        nrm1 = floor_sqrt(d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2]);
        nrm2 = floor_sqrt(d2[0] * d2[0] + d2[1] * d2[1] + d2[2] * d2[2]);
        for (int i = 0; i < 3; i++)
        begin
            u1[i] = (nrm1 != 0) ? unit_comp(d1[i], nrm1) : 128'sd0;
            u2[i] = (nrm2 != 0) ? unit_comp(d2[i], nrm2) : 128'sd0;
        end
        cosv = round_q28(u1[0] * u2[0] + u1[1] * u2[1] + u1[2] * u2[2]);
        if (cosv > ONE28)
        begin
            cosv = ONE28;
        end
        if (cosv < -ONE28)
        begin
            cosv = -ONE28;
        end
        sinsq = ONE56 - cosv * cosv;
        par = (nrm1 == 0) || (nrm2 == 0) || (sinsq == 0)
            || (sinsq < $signed({96'd0, cut} << 24));
        s1 = 0;
        s2 = 0;
        if (par)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c1[i] = p1[i];
                c2[i] = p2[i];
            end
        end
        else
        begin
            t1 = 0;
            t2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                t1 += (p1[i] - p2[i]) * u1[i];
                t2 += (p1[i] - p2[i]) * u2[i];
            end
            t1 = round_q28(t1);
            t2 = round_q28(t2);
            s1 = line_param(t2 * cosv - t1 * ONE28, sinsq);
            s2 = line_param(t2 * ONE28 - t1 * cosv, sinsq);
            for (int i = 0; i < 3; i++)
            begin
                c1[i] = clamp32(p1[i] + round_q28(u1[i] * s1));
                c2[i] = clamp32(p2[i] + round_q28(u2[i] * s2));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            dd[i] = c1[i] - c2[i];
            r.n1[i] = c1[i][31:0];
            r.n2[i] = c2[i][31:0];
        end
        g3 = floor_sqrt(dd[0] * dd[0] + dd[1] * dd[1] + dd[2] * dd[2]);
        g2 = floor_sqrt(dd[0] * dd[0] + dd[1] * dd[1]);
        r.g3 = (g3 > 128'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : g3[32:0];
        r.gxy = (g2 > 128'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : g2[32:0];
        r.s1 = s1[31:0];
        r.s2 = s2[31:0];
        r.par = par;
        r.side = par ? SIDE_ZERO : ((s2 > 0) ? SIDE_POS : SIDE_NEG);
        return r;
    endfunction

    // Flatten a result into fields for reporting.
    function automatic logic [11:0][63:0] approach_fields(input approach_t r);
        logic [11:0][63:0] f;
        f[0] = r.s1;
        f[1] = r.s2;
        for (int i = 0; i < 3; i++)
        begin
            f[2 + i] = r.n1[i];
            f[5 + i] = r.n2[i];
        end
        f[8] = r.g3;
        f[9] = r.gxy;
        f[10] = r.par;
        f[11] = r.side;
        return f;
    endfunction

    // Signed value spread over [-span, span].
    function automatic logic [31:0] spread(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic line_pair_t pair_of(input logic [0:2][31:0] p1, input logic [0:2][31:0] d1,
                                           input logic [0:2][31:0] p2, input logic [0:2][31:0] d2);
        line_pair_t a;
        a.p1 = p1;
        a.d1 = d1;
        a.p2 = p2;
        a.d2 = d2;
        return a;
    endfunction

    // Random line pair; most are well-formed geometry with random content.
    function automatic line_pair_t random_pair();
        line_pair_t a;
        int unsigned kind;
        int unsigned span;
        kind = $urandom_range(0, 9);
        span = 32'd1 << $urandom_range(4, 24);
        for (int i = 0; i < 3; i++)
        begin
            a.p1[i] = spread(span);
            a.p2[i] = spread(span);
            a.d1[i] = spread(32'd1 << $urandom_range(2, 20));
            a.d2[i] = spread(32'd1 << $urandom_range(2, 20));
        end
        if (kind >= 4 && kind <= 5)
        begin
            a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else if (kind <= 7 && kind >= 6)
        begin
            // Nearly parallel: small perturbation of the first direction.
            for (int i = 0; i < 3; i++)
            begin
                a.d1[i] = spread(32'd1 << 20);
                a.d2[i] = a.d1[i] + spread($urandom_range(0, 2000));
            end
        end
        else if (kind == 8)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a.d2[i] = $urandom_range(0, 1) ? a.d1[i] : -a.d1[i];
            end
        end
        else if (kind == 9)
        begin
            if ($urandom_range(0, 1))
            begin
                a.d1 = '0;
            end
            else
            begin
                a.d2 = '0;
            end
        end
        return a;
    endfunction

    // Drive the input channel: bursts of beats, with gaps between them while gaps_on is set.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                drv <= pending_pairs.pop_front();
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = gaps_on ? $urandom_range(0, 9) : 0;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall pattern, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            pattern_cnt = pattern_cnt + 1;
            if (pattern_cnt % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Sample both channels, predict on input beats, check output beats.
    always @(posedge clk)
    begin
        approach_t want;
        logic [11:0][63:0] wf;
        logic [11:0][63:0] gf;
        in_took = in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_took)
            begin
                expected_approach.push_back(predict_approach(drv, cut_copy));
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (expected_approach.size() == 0)
                begin
                    errors++;
                    $display("%0t: output beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_approach.pop_front();
                    if (want.par)
                    begin
                        parallel_seen++;
                    end
                    wf = approach_fields(want);
                    gf = approach_fields(seen);
                    for (int i = 0; i < 12; i++)
                    begin
                        if (wf[i] !== gf[i])
                        begin
                            errors++;
                            $display("%0t: field %0d mismatch, expected %h, actual %h",
                                     $time, i, wf[i], gf[i]);
                        end
                    end
                end
            end
            idle_cycles = (in_took || (out_valid && !out_stall)) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("** line_pair_closest_approach: FAILED **");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || expected_approach.size() > 0 || in_valid)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_cut(input logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        cut_copy = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus sequence: configuration phases with directed and random pairs.
    initial
    begin
        logic [31:0] cuts[5];
        logic [0:2][31:0] zero3;
        logic [0:2][31:0] ex;
        logic [0:2][31:0] ey;
        logic [0:2][31:0] ez;
        logic [0:2][31:0] big;
        logic [0:2][31:0] low;
        cuts = '{CUT_RESET, 32'd0, 32'hFFFF_FFFF, 32'd1 << 20, $urandom};
        zero3 = '0;
        ex = {32'h0001_0000, 32'd0, 32'd0};
        ey = {32'd0, 32'h0001_0000, 32'd0};
        ez = {32'd0, 32'd0, 32'h0001_0000};
        big = {3{32'h7FFF_FFFF}};
        low = {3{32'h8000_0000}};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        cut_copy = CUT_RESET;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        parallel_seen = 0;
        idle_cycles = 0;
        in_took = 0;
        gaps_on = 1;
        hold_req = 0;
        hold_left = 0;
        burst_left = 1;
        gap_left = 0;
        stall_pct = 0;
        pattern_cnt = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            write_cut(cuts[ph]);
            gaps_on = (ph != 2);
            if (ph <= 1)
            begin
                // Directed pairs: skew, parallel, zero directions, extremes.
                pending_pairs.push_back(pair_of(zero3, ex, ez, ey));
                pending_pairs.push_back(pair_of(zero3, ex, ey, ex));
                pending_pairs.push_back(pair_of(zero3, ex, ey, {32'hFFFF_0000, 32'd0, 32'd0}));
                pending_pairs.push_back(pair_of(ey, zero3, ex, ez));
                pending_pairs.push_back(pair_of(ey, ex, ex, zero3));
                pending_pairs.push_back(pair_of(big, zero3, low, zero3));
                pending_pairs.push_back(pair_of(big, low, low, big));
                pending_pairs.push_back(pair_of(low, {32'h7FFF_FFFF, 32'd0, 32'd0}, big,
                                                {32'd0, 32'h8000_0000, 32'd0}));
                pending_pairs.push_back(pair_of(big, ex, low, {32'h0001_0000, 32'd1, 32'd0}));
                pending_pairs.push_back(pair_of(low, ex, big, {32'h0001_0000, 32'd0, 32'd3}));
                pending_pairs.push_back(pair_of(ez, ex, zero3, {32'd0, 32'hFFFF_0000, 32'd0}));
                pending_pairs.push_back(pair_of(zero3, ex, zero3, ey));
                pending_pairs.push_back(pair_of(ey, ez, ey, ez));
                pending_pairs.push_back(pair_of(big, big, low, low));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pending_pairs.push_back(random_pair());
            end
            if (ph == 2)
            begin
                hold_req = 1'b1;
            end
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Run covered %0d line pairs (%0d treated as parallel) over 5 cut settings,",
                 beats_in, parallel_seen);
        $display("with %0d results checked, bursty input and a long output hold-off.",
                 beats_out);
        if (errors == 0 && expected_approach.size() == 0)
        begin
            $display("** line_pair_closest_approach: PASSED **");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", errors,
                     expected_approach.size());
            $display("** line_pair_closest_approach: FAILED **");
        end
        $finish;
    end

endmodule
